### hdl/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared widths, opcodes, side-band types and the clip helper of the
// quaternion unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int RAD_W         = 64;
    localparam int NQ            = 4;
    localparam int NRES          = 9;
    localparam int ACC_W         = 66;

    typedef logic [WORD_W-1:0]         t_word;
    typedef logic [NQ-1:0][WORD_W-1:0] t_quat;
    typedef logic [NRES-1:0][WORD_W-1:0] t_res;

    typedef enum logic [3:0] {
        CMD_MUL   = 4'd0,
        CMD_ADD   = 4'd1,
        CMD_SCALE = 4'd2,
        CMD_CONJ  = 4'd3,
        CMD_DOT   = 4'd4,
        CMD_MAGSQ = 4'd5,
        CMD_NORM  = 4'd6,
        CMD_NRM   = 4'd7,
        CMD_MAT   = 4'd8
    } t_cmd;

    typedef struct packed {
        t_res  res;
        logic  sat;
        logic  zn;
        logic  is_norm;
        logic  is_nrm;
        t_quat a;
    } t_sq_side;

    typedef struct packed {
        t_res  res;
        logic  sat;
        logic  zn;
        logic  is_norm;
        logic  is_nrm;
        t_word root;
    } t_dv_side;

    // {clipped flag, value}
    function automatic logic [WORD_W:0] clip_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] maxv;
        logic signed [ACC_W-1:0] minv;
        logic [WORD_W:0]         res;
        maxv = ACC_W'(64'sh7FFF_FFFF);
        minv = -ACC_W'(64'sh8000_0000);
        if (v > maxv) begin
            res = {1'b1, 1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < minv) begin
            res = {1'b1, 1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res = {1'b0, v[WORD_W-1:0]};
        end
        return res;
    endfunction

endpackage

### hdl/qau_isqrt.sv
// ----------------------------------------------------------------------------
// qau_isqrt
// Pipelined integer square root of a 64-bit radicand, one result bit per
// stage, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module qau_isqrt #(
    parameter int PW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [qau_pkg::RAD_W-1:0]  i_rad,
    input  logic [PW-1:0]              i_pay,
    output logic                       o_valid,
    output logic [qau_pkg::RAD_W/2-1:0] o_root,
    output logic [PW-1:0]              o_pay
);

    localparam int RADW = qau_pkg::RAD_W;
    localparam int NST  = RADW / 2;
    localparam int REMW = NST + 2;
    localparam int CURW = NST + 4;

    logic [REMW-1:0] r_rem  [0:NST-1];
    logic [NST-1:0]  r_root [0:NST-1];
    logic [RADW-1:0] r_rad  [0:NST-1];
    logic [PW-1:0]   r_pay  [0:NST-1];
    logic            r_vld  [0:NST-1];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic [REMW-1:0] w_rem;
        logic [NST-1:0]  w_root;
        logic [RADW-1:0] w_rad;
        logic [PW-1:0]   w_pay;
        logic            w_vld;
        logic [CURW-1:0] w_cur;
        logic [CURW-1:0] w_try;
        logic            w_ge;

        if (g == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_rad  = i_rad;
            assign w_pay  = i_pay;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_rad  = r_rad[g-1];
            assign w_pay  = r_pay[g-1];
            assign w_vld  = r_vld[g-1];
        end

        assign w_cur = {w_rem, w_rad[RADW-1 -: 2]};
        assign w_try = {2'b00, w_root, 2'b01};
        assign w_ge  = (w_cur >= w_try);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? REMW'(w_cur - w_try) : w_cur[REMW-1:0];
                r_root[g] <= {w_root[NST-2:0], w_ge};
                r_rad[g]  <= {w_rad[RADW-3:0], 2'b00};
                r_pay[g]  <= w_pay;
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_pay   = r_pay[NST-1];

endmodule

### hdl/qau_ndiv.sv
// ----------------------------------------------------------------------------
// qau_ndiv
// Four-lane pipelined restoring divider: a * 2^FRAC_BITS / n, truncated
// toward zero, for a quotient no larger than 2^FRAC_BITS in magnitude.
// ----------------------------------------------------------------------------
module qau_ndiv #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF,
    parameter int PW        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  qau_pkg::t_quat              i_a,
    input  logic [qau_pkg::WORD_W-1:0]  i_n,
    input  logic [PW-1:0]               i_pay,
    output logic                        o_valid,
    output qau_pkg::t_quat              o_q,
    output logic [PW-1:0]               o_pay
);

    localparam int WW  = qau_pkg::WORD_W;
    localparam int NQ  = qau_pkg::NQ;
    localparam int NST = FRAC_BITS + 1;

    logic [WW-1:0]  r_rem [0:NST-1][0:NQ-1];
    logic [NST-1:0] r_q   [0:NST-1][0:NQ-1];
    logic [NQ-1:0]  r_neg [0:NST-1];
    logic [WW-1:0]  r_n   [0:NST-1];
    logic [PW-1:0]  r_pay [0:NST-1];
    logic           r_vld [0:NST-1];

    for (genvar g = 0; g < NST; g++) begin : g_stage
        logic [NQ-1:0] w_neg;
        logic [WW-1:0] w_n;
        logic [PW-1:0] w_pay;
        logic          w_vld;

        if (g == 0) begin : g_first
            for (genvar l = 0; l < NQ; l++) begin : g_sign
                assign w_neg[l] = i_a[l][WW-1];
            end
            assign w_n   = i_n;
            assign w_pay = i_pay;
            assign w_vld = i_valid;
        end else begin : g_next
            assign w_neg = r_neg[g-1];
            assign w_n   = r_n[g-1];
            assign w_pay = r_pay[g-1];
            assign w_vld = r_vld[g-1];
        end

        for (genvar l = 0; l < NQ; l++) begin : g_lane
            logic [WW-1:0]  w_rem;
            logic [NST-1:0] w_q;
            logic           w_nb;
            logic [WW:0]    w_cur;
            logic [WW:0]    w_div;
            logic           w_ge;

            if (g == 0) begin : g_first
                logic [WW-1:0] w_abs;
                assign w_abs = i_a[l][WW-1] ? (WW'(0) - i_a[l]) : i_a[l];
                assign w_rem = {1'b0, w_abs[WW-1:1]};
                assign w_q   = '0;
                assign w_nb  = w_abs[0];
            end else begin : g_next
                assign w_rem = r_rem[g-1][l];
                assign w_q   = r_q[g-1][l];
                assign w_nb  = 1'b0;
            end

            assign w_cur = {w_rem, w_nb};
            assign w_div = {1'b0, w_n};
            assign w_ge  = (w_cur >= w_div);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g][l] <= w_ge ? WW'(w_cur - w_div) : w_cur[WW-1:0];
                    r_q[g][l]   <= {w_q[NST-2:0], w_ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g] <= w_neg;
                r_n[g]   <= w_n;
                r_pay[g] <= w_pay;
            end
        end
    end

    for (genvar l = 0; l < NQ; l++) begin : g_out
        logic [WW-1:0] w_mag;
        assign w_mag  = {{(WW-NST){1'b0}}, r_q[NST-1][l]};
        assign o_q[l] = r_neg[NST-1][l] ? (WW'(0) - w_mag) : w_mag;
    end

    assign o_valid = r_vld[NST-1];
    assign o_pay   = r_pay[NST-1];

endmodule

### hdl/quaternion_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_core
// Quaternion ALU in signed fixed point: Hamilton product, sum, scale,
// conjugate, dot, squared magnitude, norm, normalise and rotation matrix.
// ----------------------------------------------------------------------------
// Takes one beat every clock while the output is not stalled and returns one
// result beat per input beat, in order. Every operation runs through the same
// pipeline: five stages for operand capture, the sixteen 32x32 multipliers,
// two adder stages and clipping, then a 32-stage square-root pipeline and a
// (FRAC_BITS+1)-stage four-lane divider that serve norm and normalise, then
// the output register. Results saturate to 32 bits and raise o_saturated;
// normalising a zero quaternion returns zeros with o_zero_norm. Stalling
// the output holds the whole pipeline.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit_core #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic [31:0] i_a_w,
    input  logic [31:0] i_a_x,
    input  logic [31:0] i_a_y,
    input  logic [31:0] i_a_z,
    input  logic [31:0] i_b_w,
    input  logic [31:0] i_b_x,
    input  logic [31:0] i_b_y,
    input  logic [31:0] i_b_z,
    input  logic [31:0] i_scale,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_r0,
    output logic [31:0] o_r1,
    output logic [31:0] o_r2,
    output logic [31:0] o_r3,
    output logic [31:0] o_r4,
    output logic [31:0] o_r5,
    output logic [31:0] o_r6,
    output logic [31:0] o_r7,
    output logic [31:0] o_r8,
    output logic        o_zero_norm,
    output logic        o_saturated
);

    localparam int WW   = qau_pkg::WORD_W;
    localparam int AW   = qau_pkg::ACC_W;
    localparam int RADW = qau_pkg::RAD_W;
    localparam int NQ   = qau_pkg::NQ;
    localparam int NR   = qau_pkg::NRES;
    localparam int PW_SQ = $bits(qau_pkg::t_sq_side);
    localparam int PW_DV = $bits(qau_pkg::t_dv_side);

    function automatic logic signed [AW-1:0] fx(input logic signed [2*WW-1:0] p);
        logic signed [AW-1:0] e;
        e = {{(AW-2*WW){p[2*WW-1]}}, p};
        return e >>> FRAC_BITS;
    endfunction

    function automatic logic signed [AW-1:0] tx(input logic signed [2*WW-1:0] p);
        logic signed [AW-1:0] e;
        e = {{(AW-2*WW){p[2*WW-1]}}, p};
        return e >>> (FRAC_BITS - 1);
    endfunction

    function automatic logic signed [AW-1:0] ax(input logic [WW-1:0] v);
        return {{(AW-WW){v[WW-1]}}, v};
    endfunction

    logic en;

    // stage 1: operand capture
    logic                 r_s1_vld;
    logic [3:0]           r_s1_cmd;
    qau_pkg::t_quat       r_s1_a, r_s1_b, r_s1_m;
    qau_pkg::t_quat       n_s1_a, n_s1_b, n_s1_m;

    // stage 2: products
    logic                   r_s2_vld;
    logic [3:0]             r_s2_cmd;
    qau_pkg::t_quat         r_s2_a, r_s2_b;
    logic signed [2*WW-1:0] r_s2_p [0:15];

    // stage 3: partial sums
    logic                 r_s3_vld;
    logic [3:0]           r_s3_cmd;
    qau_pkg::t_quat       r_s3_a;
    logic signed [AW-1:0] r_s3_h0 [0:NR-1];
    logic signed [AW-1:0] r_s3_h1 [0:NR-1];
    logic signed [AW-1:0] n_s3_h0 [0:NR-1];
    logic signed [AW-1:0] n_s3_h1 [0:NR-1];
    logic [RADW:0]        r_s3_sa, r_s3_sb;

    // stage 4: final sums
    logic                 r_s4_vld;
    logic [3:0]           r_s4_cmd;
    qau_pkg::t_quat       r_s4_a;
    logic signed [AW-1:0] r_s4_v [0:NR-1];
    logic [RADW-1:0]      r_s4_sq;
    logic [RADW+1:0]      w_s4_sum;

    // stage 5: clipped results
    logic                 r_s5_vld;
    qau_pkg::t_sq_side    r_s5_side, n_s5_side;
    logic [RADW-1:0]      r_s5_sq;

    // root and divide
    logic                 w_sq_vld;
    logic [WW-1:0]        w_root;
    qau_pkg::t_sq_side    w_sq_side;
    qau_pkg::t_dv_side    w_dv_in;
    logic                 w_dv_vld;
    qau_pkg::t_quat       w_q;
    qau_pkg::t_dv_side    w_dv_side;

    // output
    logic                 r_o_vld;
    qau_pkg::t_res        r_o_res, n_o_res;
    logic                 r_o_zn, n_o_zn;
    logic                 r_o_sat, n_o_sat;

    assign en      = !r_o_vld || !i_stall;
    assign o_stall = !en;

    assign n_s1_a = {i_a_z, i_a_y, i_a_x, i_a_w};
    assign n_s1_b = {i_b_z, i_b_y, i_b_x, i_b_w};

    always_comb begin
        case (i_cmd)
            qau_pkg::CMD_SCALE: begin
                n_s1_m = {NQ{i_scale}};
            end
            qau_pkg::CMD_MAGSQ, qau_pkg::CMD_NORM, qau_pkg::CMD_NRM,
            qau_pkg::CMD_MAT: begin
                n_s1_m = n_s1_a;
            end
            default: begin
                n_s1_m = n_s1_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_o_vld  <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd <= i_cmd;
            r_s1_a   <= n_s1_a;
            r_s1_b   <= n_s1_b;
            r_s1_m   <= n_s1_m;

            r_s2_cmd <= r_s1_cmd;
            r_s2_a   <= r_s1_a;
            r_s2_b   <= r_s1_b;
            for (int i = 0; i < NQ; i++) begin
                for (int j = 0; j < NQ; j++) begin
                    r_s2_p[NQ*i+j] <= $signed(r_s1_a[i]) * $signed(r_s1_m[j]);
                end
            end

            r_s3_cmd <= r_s2_cmd;
            r_s3_a   <= r_s2_a;
            r_s3_h0  <= n_s3_h0;
            r_s3_h1  <= n_s3_h1;
            r_s3_sa  <= {1'b0, r_s2_p[0]} + {1'b0, r_s2_p[5]};
            r_s3_sb  <= {1'b0, r_s2_p[10]} + {1'b0, r_s2_p[15]};

            r_s4_cmd <= r_s3_cmd;
            r_s4_a   <= r_s3_a;
            for (int k = 0; k < NR; k++) begin
                r_s4_v[k] <= r_s3_h0[k] + r_s3_h1[k];
            end
            r_s4_sq  <= (|w_s4_sum[RADW+1:RADW]) ? {RADW{1'b1}} : w_s4_sum[RADW-1:0];

            r_s5_side <= n_s5_side;
            r_s5_sq   <= r_s4_sq;

            r_o_res <= n_o_res;
            r_o_zn  <= n_o_zn;
            r_o_sat <= n_o_sat;
        end
    end

    assign w_s4_sum = {1'b0, r_s3_sa} + {1'b0, r_s3_sb};

    always_comb begin
        logic signed [AW-1:0] pp [0:15];
        logic signed [AW-1:0] tt [0:15];
        logic signed [AW-1:0] one;
        one = AW'(1) <<< FRAC_BITS;
        for (int k = 0; k < 16; k++) begin
            pp[k] = fx(r_s2_p[k]);
            tt[k] = tx(r_s2_p[k]);
        end
        for (int k = 0; k < NR; k++) begin
            n_s3_h0[k] = '0;
            n_s3_h1[k] = '0;
        end
        case (r_s2_cmd)
            qau_pkg::CMD_MUL: begin
                n_s3_h0[0] = pp[0] - pp[5];
                n_s3_h1[0] = -(pp[10] + pp[15]);
                n_s3_h0[1] = pp[1] + pp[4];
                n_s3_h1[1] = pp[11] - pp[14];
                n_s3_h0[2] = pp[2] - pp[7];
                n_s3_h1[2] = pp[8] + pp[13];
                n_s3_h0[3] = pp[3] + pp[6];
                n_s3_h1[3] = pp[12] - pp[9];
            end
            qau_pkg::CMD_ADD: begin
                for (int k = 0; k < NQ; k++) begin
                    n_s3_h0[k] = ax(r_s2_a[k]);
                    n_s3_h1[k] = ax(r_s2_b[k]);
                end
            end
            qau_pkg::CMD_SCALE: begin
                for (int k = 0; k < NQ; k++) begin
                    n_s3_h0[k] = pp[NQ*k];
                end
            end
            qau_pkg::CMD_CONJ: begin
                n_s3_h0[0] = ax(r_s2_a[0]);
                for (int k = 1; k < NQ; k++) begin
                    n_s3_h0[k] = -ax(r_s2_a[k]);
                end
            end
            qau_pkg::CMD_DOT: begin
                n_s3_h0[0] = pp[0] + pp[5];
                n_s3_h1[0] = pp[10] + pp[15];
            end
            qau_pkg::CMD_MAT: begin
                n_s3_h0[0] = one - tt[10];
                n_s3_h1[0] = -tt[15];
                n_s3_h0[1] = tt[6];
                n_s3_h1[1] = tt[3];
                n_s3_h0[2] = tt[7];
                n_s3_h1[2] = -tt[2];
                n_s3_h0[3] = tt[6];
                n_s3_h1[3] = -tt[3];
                n_s3_h0[4] = one - tt[5];
                n_s3_h1[4] = -tt[15];
                n_s3_h0[5] = tt[11];
                n_s3_h1[5] = tt[1];
                n_s3_h0[6] = tt[7];
                n_s3_h1[6] = tt[2];
                n_s3_h0[7] = tt[11];
                n_s3_h1[7] = -tt[1];
                n_s3_h0[8] = one - tt[5];
                n_s3_h1[8] = -tt[10];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [WW:0]     cw;
        logic [RADW-1:0] msq;
        n_s5_side.sat = 1'b0;
        for (int k = 0; k < NR; k++) begin
            cw = qau_pkg::clip_word(r_s4_v[k]);
            n_s5_side.res[k] = cw[WW-1:0];
            n_s5_side.sat    = n_s5_side.sat | cw[WW];
        end
        msq = r_s4_sq >> FRAC_BITS;
        if (r_s4_cmd == qau_pkg::CMD_MAGSQ) begin
            n_s5_side.res[0] = (|msq[RADW-1:WW-1]) ? {1'b0, {(WW-1){1'b1}}} : msq[WW-1:0];
            n_s5_side.sat    = |msq[RADW-1:WW-1];
        end
        n_s5_side.is_norm = (r_s4_cmd == qau_pkg::CMD_NORM);
        n_s5_side.is_nrm  = (r_s4_cmd == qau_pkg::CMD_NRM);
        n_s5_side.zn      = (r_s4_cmd == qau_pkg::CMD_NRM) && (r_s4_sq == '0);
        n_s5_side.a       = r_s4_a;
    end

    qau_isqrt #(
        .PW (PW_SQ)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_vld),
        .i_rad   (r_s5_sq),
        .i_pay   (r_s5_side),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_pay   (w_sq_side)
    );

    assign w_dv_in.res     = w_sq_side.res;
    assign w_dv_in.sat     = w_sq_side.sat;
    assign w_dv_in.zn      = w_sq_side.zn;
    assign w_dv_in.is_norm = w_sq_side.is_norm;
    assign w_dv_in.is_nrm  = w_sq_side.is_nrm;
    assign w_dv_in.root    = w_root;

    qau_ndiv #(
        .FRAC_BITS (FRAC_BITS),
        .PW        (PW_DV)
    ) u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_sq_vld),
        .i_a     (w_sq_side.a),
        .i_n     (w_root),
        .i_pay   (w_dv_in),
        .o_valid (w_dv_vld),
        .o_q     (w_q),
        .o_pay   (w_dv_side)
    );

    always_comb begin
        n_o_res = w_dv_side.res;
        n_o_zn  = w_dv_side.zn;
        n_o_sat = w_dv_side.sat;
        if (w_dv_side.is_nrm && !w_dv_side.zn) begin
            for (int k = 0; k < NQ; k++) begin
                n_o_res[k] = w_q[k];
            end
            n_o_sat = 1'b0;
        end
        if (w_dv_side.is_norm) begin
            n_o_res[0] = w_dv_side.root[WW-1] ? {1'b0, {(WW-1){1'b1}}} : w_dv_side.root;
            n_o_sat    = w_dv_side.root[WW-1];
        end
    end

    assign o_valid     = r_o_vld;
    assign o_r0        = r_o_res[0];
    assign o_r1        = r_o_res[1];
    assign o_r2        = r_o_res[2];
    assign o_r3        = r_o_res[3];
    assign o_r4        = r_o_res[4];
    assign o_r5        = r_o_res[5];
    assign o_r6        = r_o_res[6];
    assign o_r7        = r_o_res[7];
    assign o_r8        = r_o_res[8];
    assign o_zero_norm = r_o_zn;
    assign o_saturated = r_o_sat;

endmodule
